### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the deframer modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define CLD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the usual clk_i and rst_ni
`define CLD_ASSERT(lbl, prop, msg) \
  `CLD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### design/cld_pkg.sv
// ---------------------------------------------------------------------------
// cld_pkg
// types and constants of the content length deframer
// ---------------------------------------------------------------------------
package cld_pkg;

  localparam int unsigned KEY_LEN = 15;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_DROP  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_SPACE = 3'd1,
    PH_DIGIT = 3'd2,
    PH_DONE  = 3'd3,
    PH_BAD   = 3'd4
  } phase_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } cld_res_t;

  // characters of "Content-Length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### design/cld_scan.sv
// ---------------------------------------------------------------------------
// cld_scan
// header parser and body counter, one byte per step
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cld_scan import cld_pkg::*; #(
  parameter int unsigned LEN_BITS = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output cld_res_t   res_o
);

  logic                in_body_q, in_body_d;
  logic [1:0]          sep_q, sep_d;
  logic [3:0]          key_q, key_d;
  phase_e              phase_q, phase_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;

  logic                is_digit;
  logic [3:0]          digit;
  logic [3:0]          key_idx;
  logic [LEN_BITS+3:0] len_next;
  logic                hdr_end;
  logic                len_ok;

  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit    = 4'(byte_i - CHAR_ZERO);
  assign key_idx  = (key_q == 4'(KEY_LEN)) ? 4'd0 : key_q;
  // len * 10 + digit
  assign len_next = {3'b000, len_q, 1'b0} + {1'b0, len_q, 3'b000}
                  + {{LEN_BITS{1'b0}}, digit};

  always_comb begin
    in_body_d = in_body_q;
    sep_d     = sep_q;
    key_d     = key_q;
    phase_d   = phase_q;
    len_d     = len_q;
    rem_d     = rem_q;
    hdr_end   = 1'b0;
    len_ok    = 1'b0;
    res_o     = '{valid: 1'b0, kind: KIND_BODY, data: 8'h00, last: 1'b0};

    if (in_body_q) begin
      if (rem_q != '0) begin
        rem_d = rem_q - LEN_BITS'(1);
      end
      res_o.valid = 1'b1;
      res_o.data  = byte_i;
      res_o.last  = (rem_d == '0);
      if (rem_d == '0) begin
        in_body_d = 1'b0;
      end
    end else begin
      // length field
      case (phase_q)
        PH_SEEK: begin
          if (byte_i == key_char(key_idx)) begin
            key_d = key_idx + 4'd1;
          end else begin
            key_d = (byte_i == key_char(4'd0)) ? 4'd1 : 4'd0;
          end
          if (key_d == 4'(KEY_LEN)) begin
            phase_d = PH_SPACE;
          end
        end
        PH_SPACE: begin
          if (byte_i != CHAR_SPACE) begin
            if (is_digit) begin
              len_d   = LEN_BITS'(digit);
              phase_d = PH_DIGIT;
            end else begin
              phase_d = PH_BAD;
            end
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            if (len_next[LEN_BITS+3:LEN_BITS] != 4'd0) begin
              phase_d = PH_BAD;
            end else begin
              len_d = len_next[LEN_BITS-1:0];
            end
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_BAD;
        end
      endcase

      // header terminator
      case (sep_q)
        2'd1:    sep_d = (byte_i == CHAR_LF) ? 2'd2 : ((byte_i == CHAR_CR) ? 2'd1 : 2'd0);
        2'd2:    sep_d = (byte_i == CHAR_CR) ? 2'd3 : 2'd0;
        2'd3: begin
          if (byte_i == CHAR_LF) begin
            hdr_end = 1'b1;
          end else begin
            sep_d = (byte_i == CHAR_CR) ? 2'd1 : 2'd0;
          end
        end
        default: sep_d = (byte_i == CHAR_CR) ? 2'd1 : 2'd0;
      endcase

      if (hdr_end) begin
        len_ok  = (phase_d == PH_DONE) || (phase_d == PH_DIGIT);
        sep_d   = 2'd0;
        key_d   = 4'd0;
        phase_d = PH_SEEK;
        len_d   = '0;
        if (!len_ok) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_DROP;
        end else if (len_q == '0 && phase_q != PH_DIGIT && phase_q != PH_SPACE) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_EMPTY;
        end else if ((phase_q == PH_DIGIT || phase_q == PH_SPACE) && len_q == '0) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_EMPTY;
        end else begin
          in_body_d = 1'b1;
          rem_d     = len_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      sep_q     <= 2'd0;
      key_q     <= 4'd0;
      phase_q   <= PH_SEEK;
      len_q     <= '0;
      rem_q     <= '0;
    end else if (step_i) begin
      in_body_q <= in_body_d;
      sep_q     <= sep_d;
      key_q     <= key_d;
      phase_q   <= phase_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
    end
  end

  `CLD_ASSERT(a_hdr_clear_in_body, in_body_q |-> (phase_q == PH_SEEK && key_q == 4'd0 && sep_q == 2'd0), "header state not cleared in body")
  `CLD_ASSERT(a_body_nonzero, $rose(in_body_q) |-> (rem_q != '0), "body entered with zero length")
  `CLD_ASSERT(a_last_leaves_body, (step_i && res_o.valid && res_o.last) |=> !in_body_q, "last byte did not end body")

endmodule

### design/content_length_deframer.sv
// ---------------------------------------------------------------------------
// content_length_deframer
// splits a byte stream into messages framed by a Content-Length header
// ---------------------------------------------------------------------------
// Takes one byte per cycle and, while the output is not stalled, sustains one
// byte per cycle with no bubbles; a result is registered: its byte passes the
// input register, then the parse logic into the result register. A byte
// waiting behind a stalled result holds the input register and stalls the
// input. The per-byte parse state update is the single loop that sets this
// rate. A header without a usable length gives a drop result, a zero length
// an empty-message result, and a valid length passes the following body
// bytes straight through, last one flagged.
`include "assert_macros.svh"

module content_length_deframer import cld_pkg::*; #(
  parameter int unsigned LEN_BITS = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  kind_e      out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       adv;
  logic       step;
  cld_res_t   res;

  // result register free or being emptied
  assign adv        = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_valid_d = in_stall_o ? 1'b1 : in_valid_i;
  assign out_valid_d = adv ? (step && res.valid) : out_valid_q;

  cld_scan #(
    .LEN_BITS(LEN_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    if (step && res.valid) begin
      out_kind_q <= res.kind;
      out_byte_q <= res.data;
      out_last_q <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `CLD_ASSERT(a_stall_needs_item, in_stall_o |-> in_valid_q, "stall without a held byte")
  `CLD_ASSERT(a_marker_fields_zero, (out_valid_o && out_kind_o != KIND_BODY) |-> (out_byte_o == 8'h00 && !out_last_o), "marker with nonzero fields")
  `CLD_ASSERT(a_held_byte_kept, (in_valid_q && !step) |=> (in_valid_q && $stable(in_byte_q)), "held byte lost")

endmodule

### verif/deframe_checker.sv
// ---------------------------------------------------------------------------
// deframe_checker
// watches both channels of the content length deframer, predicts the
// result of every byte transfer from its own copy of the parse state and
// compares each output transfer with the oldest outstanding prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module deframe_checker import cld_pkg::*; #(
  parameter int unsigned LEN_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  out_kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic        out_last_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned bodies_o,
  output int unsigned empties_o,
  output int unsigned drops_o
);

  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "Content-Length:";
  localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 1;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } frame_res_t;

  frame_res_t          results_due[$];
  logic                body_mode;
  logic [1:0]          sep_cnt;
  logic [3:0]          key_cnt;
  phase_e              phase;
  logic [LEN_BITS-1:0] len_acc;
  logic [LEN_BITS-1:0] body_left;
  int unsigned         n_err, n_body, n_empty, n_drop;

  task automatic queue_result(input frame_res_t r);
    results_due.insert(results_due.size(), r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic                is_digit;
    logic                sep_done;
    logic                len_ok;
    logic [LEN_BITS-1:0] len_got;
    longint unsigned     next_len;
    frame_res_t          res;
    is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    res.data = '0;
    res.last = 1'b0;
    if (body_mode) begin
      if (body_left != 0) body_left = body_left - 1'b1;
      res.kind = KIND_BODY;
      res.data = b;
      res.last = (body_left == 0);
      if (body_left == 0) body_mode = 1'b0;
      queue_result(res);
    end else begin
      case (phase)
        PH_SEEK: begin
          if (key_cnt >= KEY_LEN) key_cnt = '0;
          if (b == KEY_TEXT[8*(KEY_LEN-1-key_cnt) +: 8]) begin
            key_cnt = key_cnt + 1'b1;
          end else begin
            key_cnt = (b == KEY_TEXT[8*(KEY_LEN-1) +: 8]) ? 4'd1 : 4'd0;
          end
          if (key_cnt == KEY_LEN) phase = PH_SPACE;
        end
        PH_SPACE: begin
          if (b != CHAR_SPACE) begin
            if (is_digit) begin
              len_acc = LEN_BITS'(b - CHAR_ZERO);
              phase   = PH_DIGIT;
            end else begin
              phase = PH_BAD;
            end
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            next_len = 64'(len_acc);
            next_len = next_len * 10 + 64'(b - CHAR_ZERO);
            if (next_len > LEN_MAX) phase = PH_BAD;
            else len_acc = next_len[LEN_BITS-1:0];
          end else begin
            phase = PH_DONE;
          end
        end
        PH_DONE: ;
        default: phase = PH_BAD;
      endcase

      sep_done = 1'b0;
      case (sep_cnt)
        2'd1: sep_cnt = (b == CHAR_LF) ? 2'd2 : ((b == CHAR_CR) ? 2'd1 : 2'd0);
        2'd2: sep_cnt = (b == CHAR_CR) ? 2'd3 : 2'd0;
        2'd3: begin
          if (b == CHAR_LF) sep_done = 1'b1;
          else sep_cnt = (b == CHAR_CR) ? 2'd1 : 2'd0;
        end
        default: sep_cnt = (b == CHAR_CR) ? 2'd1 : 2'd0;
      endcase

      if (sep_done) begin
        len_ok  = (phase == PH_DONE) || (phase == PH_DIGIT);
        len_got = len_acc;
        sep_cnt = '0;
        key_cnt = '0;
        phase   = PH_SEEK;
        len_acc = '0;
        if (!len_ok) begin
          res.kind = KIND_DROP;
          queue_result(res);
        end else if (len_got == 0) begin
          res.kind = KIND_EMPTY;
          queue_result(res);
        end else begin
          body_mode = 1'b1;
          body_left = len_got;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_res_t want;
    if (!rst_ni) begin
      results_due.delete();
      body_mode = 1'b0;
      sep_cnt   = '0;
      key_cnt   = '0;
      phase     = PH_SEEK;
      len_acc   = '0;
      body_left = '0;
      n_err     = 0;
      n_body    = 0;
      n_empty   = 0;
      n_drop    = 0;
      errors_o  <= 0;
      pending_o <= 0;
      bodies_o  <= 0;
      empties_o <= 0;
      drops_o   <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) deframe_byte(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          if (n_err < 10) begin
            $display("%0t: unexpected transfer kind %0d byte %02h last %0b",
                     $time, out_kind_i, out_byte_i, out_last_i);
          end
          n_err++;
        end else begin
          want = results_due.pop_front();
          if (want.kind != out_kind_i || want.data != out_byte_i || want.last != out_last_i)
          begin
            if (n_err < 10) begin
              $display("%0t: expected kind %0d byte %02h last %0b, %s %0d byte %02h last %0b",
                       $time, want.kind, want.data, want.last, "got kind",
                       out_kind_i, out_byte_i, out_last_i);
            end
            n_err++;
          end
          case (want.kind)
            KIND_BODY:  n_body++;
            KIND_EMPTY: n_empty++;
            default:    n_drop++;
          endcase
        end
      end
      errors_o  <= n_err;
      pending_o <= results_due.size();
      bodies_o  <= n_body;
      empties_o <= n_empty;
      drops_o   <= n_drop;
    end
  end

endmodule

### verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// byte stream stimulus for the content length deframer: directed headers
// for every framing corner, then random messages, broken headers and noise
// under several idling mixes, including a long output hold-off
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb import cld_pkg::*; ();

  localparam int unsigned     LEN_BITS     = 31;
  localparam longint unsigned LEN_MAX      = (64'd1 << LEN_BITS) - 1;
  localparam int unsigned     CYCLE_LIMIT  = 200000;
  localparam int unsigned     HOLD_CYCLES  = 300;
  localparam int unsigned     PHASE_BYTES  = 40;
  localparam int unsigned     DRAIN_CYCLES = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic        out_last_o;

  int unsigned errors, pending, bodies, empties, drops;
  int unsigned idle_pct, stall_pct, n_sent;
  int unsigned cycle_cnt = 0;
  logic        hold_off;
  logic [7:0]  tx_bytes[$];

  content_length_deframer #(.LEN_BITS(LEN_BITS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  deframe_checker #(.LEN_BITS(LEN_BITS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_i  (out_kind_o),
    .out_byte_i  (out_byte_o),
    .out_last_i  (out_last_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .bodies_o    (bodies),
    .empties_o   (empties),
    .drops_o     (drops)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  task automatic add_byte(input logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    add_byte(CHAR_CR);
    add_byte(CHAR_LF);
  endtask

  // random bytes, with line ends mixed in now and then
  task automatic push_random(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(7) == 0) add_byte($urandom_range(1) ? CHAR_CR : CHAR_LF);
      else add_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic push_field_line();
    push_text("X-");
    repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(126, 33)));
    push_text(": ");
    repeat ($urandom_range(8)) add_byte(8'($urandom_range(126, 33)));
    push_line("");
  endtask

  task automatic gen_message();
    int unsigned pick, len, bad;
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(80, 13) : $urandom_range(12);
    repeat ($urandom_range(2)) push_field_line();
    if (pick < 70) begin
      push_text("Content-Length:");
      repeat ($urandom_range(3)) push_text(" ");
      if ($urandom_range(4) == 0) push_text("00");
      push_text($sformatf("%0d", len));
      if ($urandom_range(4) == 0) push_text(";q=1");
      push_line("");
      if ($urandom_range(5) == 0) push_line("Content-Length: 99");
      repeat ($urandom_range(2)) push_field_line();
      push_line("");
      push_random(len);
    end else if (pick < 88) begin
      case ($urandom_range(5))
        0: push_text("Content-Type: text");
        1: begin
          push_text("Content-Length:");
          do bad = $urandom_range(255);
          while (bad == CHAR_SPACE || (bad >= CHAR_ZERO && bad <= CHAR_NINE));
          add_byte(8'(bad));
          push_text($sformatf("%0d", len));
        end
        2: push_text($sformatf("Content-Length: -%0d", len));
        3: push_text($sformatf("Content-Length: %0d", LEN_MAX + 1 + $urandom));
        4: push_text($sformatf("content-length: %0d", len));
        default: push_text($sformatf("Content-Length %0d", len));
      endcase
      push_line("");
      repeat ($urandom_range(1)) push_field_line();
      push_line("");
    end else begin
      push_random($urandom_range(15, 1));
      push_line("");
      push_line("");
    end
  endtask

  task automatic send_stream();
    while (tx_bytes.size() != 0) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i  <= tx_bytes.pop_front();
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      n_sent++;
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input bit squeeze);
    idle_pct  = idle;
    stall_pct = stall;
    while (tx_bytes.size() < PHASE_BYTES) gen_message();
    fork
      send_stream();
      if (squeeze) begin
        // output held off while the sender keeps offering bytes
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join
  endtask

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_byte_i   <= '0;
    hold_off    <= 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    n_sent      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_line("Content-Length: 3");
    push_line("");
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(CHAR_CR);
    push_line("Content-Length: 0");
    push_line("");
    push_line("Content-Length: 1");
    push_line("");
    add_byte(CHAR_LF);
    push_line("Host: a");
    push_line("");
    push_line("Content-Length:\t5");
    push_line("");
    push_line("Content-Length: -5");
    push_line("");
    push_line("Content-Length: -0");
    push_line("");
    push_line($sformatf("Content-Length: %0d", LEN_MAX + 1));
    push_line("");
    push_line("Content-Length:");
    push_line("");
    push_line("content-length: 4");
    push_line("");
    push_line("Content-Length: 2");
    push_line("Content-Length: 9");
    push_line("");
    push_text("ok");
    push_line("Content-Length:   007abc");
    push_line("X: y");
    push_line("");
    push_text("seven!!");
    // partial key restart, body made of line ends only
    push_text("ContentContent-Length:4");
    push_line("");
    push_line("");
    push_line("");
    push_line("");
    push_text("a");
    add_byte(CHAR_CR);
    push_line("");
    push_line("");
    send_stream();

    run_phase(0, 0, 1'b0);
    run_phase(55, 0, 1'b0);
    run_phase(0, 55, 1'b0);
    run_phase(24, 24, 1'b1);

    // largest length last, its body never completes
    push_line($sformatf("Content-Length: %0d", LEN_MAX));
    push_line("");
    push_random(20);
    send_stream();
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d bytes; checked %0d body bytes, %0d empty messages, %0d dropped headers",
             n_sent, bodies, empties, drops);
    $display("idling mixes: none, sender, receiver, both with a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/cld_pkg.sv
design/cld_scan.sv
design/content_length_deframer.sv
verif/deframe_checker.sv
verif/tb.sv
